// File: rtl/byte_entropy_scorer_macros.svh
// Assertion macros for the byte entropy scorer.
`ifndef BYTE_ENTROPY_SCORER_MACROS_SVH
`define BYTE_ENTROPY_SCORER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BES_ASSERT_HOLDS(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bes check failed");
// Next-cycle implication.
`define BES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bes check failed");
`else
`define BES_ASSERT_HOLDS(label, ante, cons)
`define BES_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/bes_pkg.sv
// Shared constants, codes and control structs of the byte entropy scorer.
package bes_pkg;
	localparam int BinCount = 256;
	localparam int BinW     = 8;
	localparam int CntW     = 14;
	localparam int LogIntW  = 4;
	localparam int LogFracW = 16;
	localparam int LogW     = LogIntW + LogFracW;
	localparam int MantW    = 32;
	localparam int SumW     = 40;
	localparam int QuoW     = 20;
	localparam int RemW     = 15;
	localparam int LogSteps = LogFracW;
	localparam int DivSteps = QuoW;

	localparam logic [CntW-1:0] MaxSampleBytes = 14'd8192;

	localparam logic [7:0] TierOneReset   = 8'd64;
	localparam logic [7:0] TierTwoReset   = 8'd128;
	localparam logic [7:0] TierThreeReset = 8'd192;

	// register indexes
	localparam logic [1:0] CfgTierOne   = 2'd0;
	localparam logic [1:0] CfgTierTwo   = 2'd1;
	localparam logic [1:0] CfgTierThree = 2'd2;

	// tier codes
	localparam logic [1:0] TierZero  = 2'd0;
	localparam logic [1:0] TierOne   = 2'd1;
	localparam logic [1:0] TierTwo   = 2'd2;
	localparam logic [1:0] TierThree = 2'd3;

	typedef struct packed {
		logic clr_sum;
		logic log_start;
		logic log_src_n;
		logic mul;
		logic acc;
		logic div_start;
		logic score;
		logic tier;
		logic emit;
	} bes_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic bin_zero;
		logic log_busy;
		logic div_busy;
		logic out_free;
	} bes_stat_t;

	typedef struct packed {
		logic            zero_en;
		logic [BinW-1:0] addr;
	} bes_hcmd_t;
endpackage

// File: rtl/bes_hist.sv
// Histogram memory with pipelined read-modify-write increment and a zeroing port.
module bes_hist (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     inc_valid,
	input  logic [bes_pkg::BinW-1:0] inc_addr,
	input  bes_pkg::bes_hcmd_t       hcmd,
	output logic [bes_pkg::CntW-1:0] rd_data
);
	import bes_pkg::*;

	logic [CntW-1:0] mem [BinCount];
	logic [CntW-1:0] rd_q;
	logic [BinW-1:0] raddr;
	logic            inc_v_s1;
	logic [BinW-1:0] addr_s1;
	logic            wr_v_q;
	logic [BinW-1:0] wr_addr_q;
	logic [CntW-1:0] wr_val_q;
	logic [CntW-1:0] inc_cnt;

	assign raddr   = hcmd.zero_en ? hcmd.addr : inc_addr;
	assign rd_data = rd_q;

	// forward the previous write when the same bin comes again
	assign inc_cnt = ((wr_v_q && (wr_addr_q == addr_s1)) ? wr_val_q : rd_q) + CntW'(1);

	// memory: one read, one write per cycle
	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
		if (inc_v_s1) begin
			mem[addr_s1] <= inc_cnt;
		end else if (hcmd.zero_en) begin
			mem[hcmd.addr] <= '0;
		end
	end

	// increment pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_v_s1 <= 1'b0;
			wr_v_q   <= 1'b0;
		end else begin
			inc_v_s1 <= inc_valid;
			wr_v_q   <= inc_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= inc_addr;
		wr_addr_q <= addr_s1;
		wr_val_q  <= inc_cnt;
	end
endmodule

// File: rtl/bes_dp.sv
// Datapath: length count, log2 unit, accumulator, divider, scoring and output register.
module bes_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_acc,
	input  logic                     in_present,
	output logic                     count_en,
	input  logic                     cfg_valid,
	input  logic [1:0]               cfg_index,
	input  logic [7:0]               cfg_data,
	input  logic [bes_pkg::CntW-1:0] rd_data,
	input  bes_pkg::bes_cmd_t        cmd,
	output bes_pkg::bes_stat_t       stat,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [31:0]              m_tdata
);
	import bes_pkg::*;

	logic [7:0]        thr_one_q, thr_two_q, thr_three_q;
	logic [CntW-1:0]   n_q;
	// log unit
	logic              log_busy_q;
	logic [3:0]        log_cnt_q;
	logic [MantW-1:0]  m_q;
	logic [LogFracW-1:0] frac_q;
	logic [LogIntW-1:0]  top_q;
	logic [CntW-1:0]   log_x_q;
	logic [CntW-1:0]   log_x;
	logic [LogIntW-1:0]  top_c;
	logic [MantW-1:0]  m_init;
	logic [2*MantW-1:0] sq;
	logic [MantW:0]    sq_top;
	// accumulate
	logic [CntW+LogW-1:0] prod_full;
	logic [SumW-1:0]   prod_q, sum_q, t_c;
	// divider
	logic              div_busy_q;
	logic [4:0]        div_cnt_q;
	logic [RemW-1:0]   rem_q, r2, n_ext;
	logic [QuoW-1:0]   quo_q, dvd_q;
	logic              ge;
	// score
	logic [QuoW+7:0]   s28;
	logic [16:0]       s17;
	logic [15:0]       score_q;
	logic [1:0]        tier_q;
	// output
	logic              out_v_q;
	logic [31:0]       out_q;

	assign count_en = in_acc && in_present && (n_q < MaxSampleBytes);

	// config registers and sample length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_one_q   <= TierOneReset;
			thr_two_q   <= TierTwoReset;
			thr_three_q <= TierThreeReset;
			n_q         <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CfgTierOne:   thr_one_q   <= cfg_data;
					CfgTierTwo:   thr_two_q   <= cfg_data;
					CfgTierThree: thr_three_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.emit) begin
				n_q <= '0;
			end else if (count_en) begin
				n_q <= n_q + CntW'(1);
			end
		end
	end

	// log2 start: top bit index and normalized mantissa
	assign log_x = cmd.log_src_n ? n_q : rd_data;
	always_comb begin
		top_c = '0;
		for (int k = 0; k < CntW; k++) begin
			if (log_x[k]) top_c = LogIntW'(k);
		end
	end
	assign m_init = MantW'(log_x) << (5'd31 - 5'(top_c));

	// one fraction bit per cycle by squaring
	assign sq     = 64'(m_q) * 64'(m_q);
	assign sq_top = sq[2*MantW-1:MantW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_busy_q <= 1'b0;
			log_cnt_q  <= '0;
		end else if (cmd.log_start) begin
			log_busy_q <= 1'b1;
			log_cnt_q  <= '0;
		end else if (log_busy_q) begin
			log_cnt_q <= log_cnt_q + 4'd1;
			if (log_cnt_q == 4'(LogSteps-1)) log_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.log_start) begin
			m_q     <= m_init;
			frac_q  <= '0;
			top_q   <= top_c;
			log_x_q <= log_x;
		end else if (log_busy_q) begin
			if (sq_top[MantW]) begin
				m_q    <= sq_top[MantW:1];
				frac_q <= {frac_q[LogFracW-2:0], 1'b1};
			end else begin
				m_q    <= sq_top[MantW-1:0];
				frac_q <= {frac_q[LogFracW-2:0], 1'b0};
			end
		end
	end

	// c * L(c) and running sum
	assign prod_full = log_x_q * {top_q, frac_q};
	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= SumW'(prod_full);
		if (cmd.clr_sum) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + prod_q;
		end
	end

	// restoring divider, T / N
	assign t_c   = (prod_q >= sum_q) ? (prod_q - sum_q) : '0;
	assign n_ext = RemW'(n_q);
	assign r2    = {rem_q[RemW-2:0], dvd_q[QuoW-1]};
	assign ge    = (r2 >= n_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + 5'd1;
			if (div_cnt_q == 5'(DivSteps-1)) div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= t_c[QuoW+RemW-1:QuoW];
			dvd_q <= t_c[QuoW-1:0];
			quo_q <= '0;
		end else if (div_busy_q) begin
			rem_q <= ge ? (r2 - n_ext) : r2;
			dvd_q <= {dvd_q[QuoW-2:0], 1'b0};
			quo_q <= {quo_q[QuoW-2:0], ge};
		end
	end

	// score = H * 255 / 2048, saturated, then tier
	assign s28 = {quo_q, 8'd0} - {8'd0, quo_q};
	assign s17 = s28[QuoW+7:11];
	always_ff @(posedge clk) begin
		if (cmd.score) score_q <= s17[16] ? 16'hFFFF : s17[15:0];
		if (cmd.tier) begin
			priority if (score_q[15:8] < thr_one_q)   tier_q <= TierZero;
			else if (score_q[15:8] < thr_two_q)       tier_q <= TierOne;
			else if (score_q[15:8] < thr_three_q)     tier_q <= TierTwo;
			else                                      tier_q <= TierThree;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.emit) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (n_q == '0) out_q <= '0;
			else out_q <= {n_q, tier_q, score_q[7:0], score_q[15:8]};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	assign stat.n_zero   = (n_q == '0);
	assign stat.bin_zero = (rd_data == '0);
	assign stat.log_busy = log_busy_q;
	assign stat.div_busy = div_busy_q;
	assign stat.out_free = !out_v_q || m_tready;
endmodule

// File: rtl/bes_ctrl.sv
// Sequencer: histogram clear, input phase, bin walk, divide and result hand-off.
module bes_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_last_acc,
	input  bes_pkg::bes_stat_t stat,
	output bes_pkg::bes_cmd_t  cmd,
	output bes_pkg::bes_hcmd_t hcmd,
	output logic               in_ready
);
	import bes_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_RUN   = 4'd1;
	localparam logic [3:0] S_DRAIN = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_CHK   = 4'd4;
	localparam logic [3:0] S_LOG   = 4'd5;
	localparam logic [3:0] S_MUL   = 4'd6;
	localparam logic [3:0] S_ACC   = 4'd7;
	localparam logic [3:0] S_NST   = 4'd8;
	localparam logic [3:0] S_NLOG  = 4'd9;
	localparam logic [3:0] S_NMUL  = 4'd10;
	localparam logic [3:0] S_SUB   = 4'd11;
	localparam logic [3:0] S_DIV   = 4'd12;
	localparam logic [3:0] S_SCORE = 4'd13;
	localparam logic [3:0] S_TIER  = 4'd14;
	localparam logic [3:0] S_EMIT  = 4'd15;

	logic [3:0]      state_q, state_d;
	logic [BinW-1:0] bin_q, bin_d;
	logic            bin_end;

	assign bin_end  = (bin_q == BinW'(BinCount-1));
	assign in_ready = (state_q == S_RUN);

	// next state and commands
	always_comb begin
		state_d = state_q;
		bin_d   = bin_q;
		cmd     = '0;
		hcmd.zero_en = (state_q == S_CLR) || (state_q == S_RD);
		hcmd.addr    = bin_q;
		unique case (state_q)
			S_CLR: begin
				bin_d = bin_q + BinW'(1);
				if (bin_end) state_d = S_RUN;
			end
			S_RUN: if (in_last_acc) state_d = S_DRAIN;
			S_DRAIN: begin
				cmd.clr_sum = 1'b1;
				bin_d = '0;
				state_d = stat.n_zero ? S_EMIT : S_RD;
			end
			S_RD: state_d = S_CHK;
			S_CHK: begin
				if (!stat.bin_zero) begin
					cmd.log_start = 1'b1;
					state_d = S_LOG;
				end else if (bin_end) begin
					state_d = S_NST;
				end else begin
					bin_d = bin_q + BinW'(1);
					state_d = S_RD;
				end
			end
			S_LOG: if (!stat.log_busy) state_d = S_MUL;
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (bin_end) begin
					state_d = S_NST;
				end else begin
					bin_d = bin_q + BinW'(1);
					state_d = S_RD;
				end
			end
			S_NST: begin
				cmd.log_start = 1'b1;
				cmd.log_src_n = 1'b1;
				state_d = S_NLOG;
			end
			S_NLOG: if (!stat.log_busy) state_d = S_NMUL;
			S_NMUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUB;
			end
			S_SUB: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: if (!stat.div_busy) state_d = S_SCORE;
			S_SCORE: begin
				cmd.score = 1'b1;
				state_d = S_TIER;
			end
			S_TIER: begin
				cmd.tier = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_RUN;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			bin_q   <= '0;
		end else begin
			state_q <= state_d;
			bin_q   <= bin_d;
		end
	end
endmodule

// File: rtl/byte_entropy_scorer.sv
// Byte entropy scorer top level: histogram, datapath and sequencer.
// Input: one byte per cycle while a sample streams in.
// After the last beat each bin is read and checked; a filled bin also runs the log2
// squaring loop of 16 steps. Then come 20 divider steps; input is held off meanwhile.
// The result waits in an output register; the next sample may start streaming at once.
// After reset a pass over all 256 bins zeroes the histogram before any beat is taken.
`include "byte_entropy_scorer_macros.svh"
module byte_entropy_scorer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] score_whole, [15:8] score_fraction,
	                               // [17:16] tier, [31:18] sample_length
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import bes_pkg::*;

	bes_cmd_t        cmd;
	bes_stat_t       stat;
	bes_hcmd_t       hcmd;
	logic            in_acc;
	logic            count_en;
	logic [CntW-1:0] rd_data;

	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	bes_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_last_acc (in_acc && s_tlast),
		.stat        (stat),
		.cmd         (cmd),
		.hcmd        (hcmd),
		.in_ready    (s_tready)
	);

	bes_hist u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.inc_valid (count_en),
		.inc_addr  (s_tdata),
		.hcmd      (hcmd),
		.rd_data   (rd_data)
	);

	bes_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_acc     (in_acc),
		.in_present (s_tuser),
		.count_en   (count_en),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rd_data    (rd_data),
		.cmd        (cmd),
		.stat       (stat),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// input is held off after the closing beat while the walk runs
	`BES_ASSERT_NEXT(a_hold_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
	// an empty sample reports score and tier zero
	`BES_ASSERT_HOLDS(a_empty_zero, m_tvalid && (m_tdata[31:18] == 14'd0), m_tdata[17:0] == 18'd0)
	// the reported length never passes the cap
	`BES_ASSERT_HOLDS(a_len_cap, m_tvalid, m_tdata[31:18] <= MaxSampleBytes)
endmodule
